// File: hdl/ip2dd_pkg.sv
// ----------------------------------------------------------------------------
// ip2dd_pkg
// Shared types and constants for the IPv4 dot-decimal text converter.
// ----------------------------------------------------------------------------
package ip2dd_pkg;

	localparam logic [7:0] DOT_CHAR  = 8'h2E;
	localparam logic [7:0] ZERO_CHAR = 8'h30;
	localparam logic [1:0] LAST_OCTET = 2'd3;

	// Which character slot of the current octet goes to the output register.
	typedef enum logic [1:0] {
		SEL_HUND = 2'd0,
		SEL_TENS = 2'd1,
		SEL_ONES = 2'd2,
		SEL_DOT  = 2'd3
	} char_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      load;
		logic      next_octet;
		logic      emit;
		char_sel_t sel;
		logic      last;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
		logic hund_nz;
		logic tens_nz;
	} status_t;

endpackage

// File: hdl/ip2dd_dpath.sv
// ----------------------------------------------------------------------------
// ip2dd_dpath
// Address register, octet to decimal digit conversion and output register.
// ----------------------------------------------------------------------------
module ip2dd_dpath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [31:0]         address_word,
	input  logic                out_stall,
	input  ip2dd_pkg::cmd_t     cmd,
	output ip2dd_pkg::status_t  status,
	output logic                out_valid,
	output logic [7:0]          text_char,
	output logic                is_last
);

	// Binary to BCD by shift and add-three over the eight bits of an octet.
	function automatic logic [11:0] to_bcd(input logic [7:0] v);
		logic [19:0] sh;
		sh = {12'd0, v};
		for (int i = 0; i < 8; i++) begin
			if (sh[11:8] >= 4'd5) begin
				sh[11:8] = sh[11:8] + 4'd3;
			end
			if (sh[15:12] >= 4'd5) begin
				sh[15:12] = sh[15:12] + 4'd3;
			end
			if (sh[19:16] >= 4'd5) begin
				sh[19:16] = sh[19:16] + 4'd3;
			end
			sh = sh << 1;
		end
		return sh[19:8];
	endfunction

	// The first octet is converted straight from the input, so only the
	// three octets that follow it are kept.
	logic [23:0] addr_q;
	logic [11:0] bcd_q;
	logic        out_valid_q;
	logic [7:0]  text_char_q;
	logic        is_last_q;
	logic [3:0]  digit;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q <= address_word[23:0];
			bcd_q  <= to_bcd(address_word[31:24]);
		end else if (cmd.next_octet) begin
			addr_q <= {addr_q[15:0], 8'd0};
			bcd_q  <= to_bcd(addr_q[23:16]);
		end
	end

	always_comb begin
		unique case (cmd.sel)
			ip2dd_pkg::SEL_HUND: digit = bcd_q[11:8];
			ip2dd_pkg::SEL_TENS: digit = bcd_q[7:4];
			default:             digit = bcd_q[3:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (cmd.sel == ip2dd_pkg::SEL_DOT) begin
				text_char_q <= ip2dd_pkg::DOT_CHAR;
			end else begin
				text_char_q <= ip2dd_pkg::ZERO_CHAR + {4'd0, digit};
			end
			is_last_q <= cmd.last;
		end
	end

	assign status.out_free = !out_valid_q || !out_stall;
	assign status.hund_nz  = (bcd_q[11:8] != 4'd0);
	assign status.tens_nz  = (bcd_q[7:4] != 4'd0);

	assign out_valid = out_valid_q;
	assign text_char = text_char_q;
	assign is_last   = is_last_q;

endmodule

// File: hdl/ip2dd_ctrl.sv
// ----------------------------------------------------------------------------
// ip2dd_ctrl
// Character sequencer: walks the digit and dot slots of the four octets.
// ----------------------------------------------------------------------------
module ip2dd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  ip2dd_pkg::status_t  status,
	output ip2dd_pkg::cmd_t     cmd
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_HUND = 5'b00010,
		ST_TENS = 5'b00100,
		ST_ONES = 5'b01000,
		ST_DOT  = 5'b10000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] octet_q, octet_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d        = state_q;
		octet_d        = octet_q;
		cmd.load       = 1'b0;
		cmd.next_octet = 1'b0;
		cmd.emit       = 1'b0;
		cmd.sel        = ip2dd_pkg::SEL_HUND;
		cmd.last       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					octet_d  = 2'd0;
					state_d  = ST_HUND;
				end
			end
			ST_HUND: begin
				cmd.sel = ip2dd_pkg::SEL_HUND;
				if (!status.hund_nz) begin
					state_d = ST_TENS;
				end else if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_TENS;
				end
			end
			ST_TENS: begin
				cmd.sel = ip2dd_pkg::SEL_TENS;
				if (!(status.hund_nz || status.tens_nz)) begin
					state_d = ST_ONES;
				end else if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_ONES;
				end
			end
			ST_ONES: begin
				cmd.sel  = ip2dd_pkg::SEL_ONES;
				cmd.last = (octet_q == ip2dd_pkg::LAST_OCTET);
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = (octet_q == ip2dd_pkg::LAST_OCTET) ? ST_IDLE : ST_DOT;
				end
			end
			ST_DOT: begin
				cmd.sel = ip2dd_pkg::SEL_DOT;
				if (status.out_free) begin
					cmd.emit       = 1'b1;
					cmd.next_octet = 1'b1;
					octet_d        = octet_q + 2'd1;
					state_d        = ST_HUND;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			octet_q <= 2'd0;
		end else begin
			state_q <= state_d;
			octet_q <= octet_d;
		end
	end

endmodule

// File: hdl/ipv4_to_dotted_decimal_text_core.sv
// ----------------------------------------------------------------------------
// ipv4_to_dotted_decimal_text_core
// Converts a 32-bit IPv4 address into ASCII dot-decimal text, one character
// per output transfer, with is_last marking the final character.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake           Payload
//   -------  ------------------  ---------------------------------
//   input    in_valid/in_stall   address_word[31:0]
//   output   out_valid/out_stall text_char[7:0], is_last
//
// The sequencer accepts an address, then visits four character slots
// (hundreds, tens, ones, dot) per octet, three for the last octet, one slot
// per cycle, except that it stays in a slot while it has a character ready
// and the previous one still waits stalled in the output register.
// Slots with a leading zero are skipped without producing a transfer, so 7
// to 15 characters result.
// The next address is accepted while the final character still waits in the
// output register. Reset clears the sequencer and the output valid flag.
//
module ipv4_to_dotted_decimal_text_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] address_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  text_char,
	output logic        is_last
);

	// Commands and status between the sequencer and the datapath.
	ip2dd_pkg::cmd_t    cmd;
	ip2dd_pkg::status_t status;

	// The sequencer owns the input handshake and decides which slot of the
	// current octet is written to the output register in each cycle.
	ip2dd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath holds the address, converts the current octet to three
	// decimal digits and drives the output register.
	ip2dd_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.address_word (address_word),
		.out_stall    (out_stall),
		.cmd          (cmd),
		.status       (status),
		.out_valid    (out_valid),
		.text_char    (text_char),
		.is_last      (is_last)
	);

endmodule

// File: hdl/ip2dd_chk.sv
// ----------------------------------------------------------------------------
// ip2dd_chk
// Port-level checks for the IPv4 dot-decimal text converter.
// ----------------------------------------------------------------------------
module ip2dd_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  text_char,
	input logic        is_last
);

	// A stalled output transfer keeps its character.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(text_char) && $stable(is_last))
		else $error("output changed while stalled");

	// Only digits and dots are produced.
	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (text_char == 8'h2E) ||
			((text_char >= 8'h30) && (text_char <= 8'h39)))
		else $error("character is neither digit nor dot");

	// The text never ends on a dot.
	a_dot_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (text_char == 8'h2E) |-> !is_last)
		else $error("dot marked as last character");

	// After an address transfer the converter is busy with it.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second address accepted back to back");

endmodule

bind ipv4_to_dotted_decimal_text_core ip2dd_chk u_ip2dd_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.text_char (text_char),
	.is_last   (is_last)
);
